### src/rc_frame_search_and_stick_scaler_top_assert.svh
// assertion macros used by the checker file
`ifndef RC_FRAME_SEARCH_AND_STICK_SCALER_TOP_ASSERT_SVH
`define RC_FRAME_SEARCH_AND_STICK_SCALER_TOP_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define RCFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define RCFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/rcfs_pkg.sv
// ----------------------------------------------------------------------------
// rcfs_pkg
// Types, constants and register codes of the rc frame search and stick scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfs_pkg;

  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CHANNELS    = 4;
  localparam int unsigned CFG_REGS    = 8;
  localparam int unsigned CFG_IDX_W   = $clog2(CFG_REGS);
  localparam int unsigned DIV_STEPS   = 15;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

  localparam logic [15:0] STEER_CUTOFF    = 16'd2100;
  localparam logic [15:0] THROTTLE_CUTOFF = 16'd2100;
  localparam logic [14:0] Q_ONE           = 15'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEER_NEUTRAL    = 3'd0,
    REG_STEER_RADIUS     = 3'd1,
    REG_STEER_TOP        = 3'd2,
    REG_STEER_BOTTOM     = 3'd3,
    REG_THROTTLE_NEUTRAL = 3'd4,
    REG_THROTTLE_RADIUS  = 3'd5,
    REG_THROTTLE_TOP     = 3'd6,
    REG_THROTTLE_BOTTOM  = 3'd7
  } rcfs_reg_e;

  localparam logic [15:0] CFG_RESET [CFG_REGS] = '{
    16'd1500, 16'd20, 16'd2000, 16'd1000,
    16'd1500, 16'd20, 16'd2000, 16'd1000
  };

  typedef enum logic [1:0] {
    LS_OK       = 2'd0,
    LS_NO_FRAME = 2'd1,
    LS_RANGE    = 2'd2
  } rcfs_link_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rcfs_in_t;

  typedef struct packed {
    logic [1:0]         link_status;
    logic signed [15:0] steer_level;
    logic signed [15:0] throttle_level;
    logic [15:0]        aux_one_word;
    logic [15:0]        aux_two_word;
  } rcfs_out_t;

  typedef struct packed {
    logic [15:0] neutral;
    logic [15:0] radius;
    logic [15:0] top;
    logic [15:0] bottom;
  } rcfs_chan_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_STEER,
    ST_THR,
    ST_OUT
  } rcfs_state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_DIFF,
    SC_SEL,
    SC_LOAD,
    SC_DIV,
    SC_FIN
  } rcfs_scale_state_e;

endpackage

`default_nettype wire

### src/rc_frame_search_and_stick_scaler_top.sv
// ----------------------------------------------------------------------------
// rc_frame_search_and_stick_scaler_top
// Frame search over received bytes and dead zone scaling of the stick words.
// ----------------------------------------------------------------------------
// Each request is one received byte. A byte is taken with no stall after it
// while the window is still filling or a frame was already found in the
// buffer; once the ten-byte window is full and no frame is latched yet, the
// byte is followed by a checksum pass through the single byte adder, during
// which the block stalls. The last byte of a buffer then runs steering and
// throttle through one shared scaler (a start strobe, the DIFF, SEL and LOAD
// setup states, up to fifteen divider steps and a finish state; the dead zone
// skips the divider), so a buffer end stalls the input until the result is
// loaded, which waits while the previous result has not been taken yet. The
// result sits in an output register until taken; no clearing pass is needed
// after reset.
`default_nettype none

module rc_frame_search_and_stick_scaler_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  rcfs_pkg::rcfs_in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output rcfs_pkg::rcfs_out_t            out_data_o,
  input  wire                            cfg_we_i,
  input  wire  [rcfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [15:0]                    cfg_wdata_i
);

  localparam int unsigned LastIdx = rcfs_pkg::FRAME_BYTES - 2;

  rcfs_pkg::rcfs_state_e state_q, state_d;

  logic [15:0] cfg_q [rcfs_pkg::CFG_REGS];
  logic [7:0]  win_q [rcfs_pkg::FRAME_BYTES];
  logic [15:0] words_q [rcfs_pkg::CHANNELS];
  logic [rcfs_pkg::FILL_W-1:0] fill_q;
  logic [rcfs_pkg::FILL_W-1:0] fill_next;
  logic        found_q;
  logic        last_q;
  logic [rcfs_pkg::IDX_W-1:0] idx_q;
  logic [7:0]  sum_q;
  logic [7:0]  sum_next;
  logic        start_q;
  logic signed [15:0] steer_q;

  logic        in_acc;
  logic        out_load;
  logic        sum_done;
  logic        frame_ok;

  rcfs_pkg::rcfs_chan_cfg_t chan_cfg;
  logic [15:0] raw;
  logic [15:0] cutoff;
  logic        scale_done;
  logic signed [15:0] level;
  logic [1:0]  status;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign fill_next = (fill_q < rcfs_pkg::FILL_W'(rcfs_pkg::FRAME_BYTES)) ?
                     fill_q + 1'b1 : fill_q;
  assign sum_next  = sum_q + win_q[idx_q];
  assign sum_done  = (idx_q == rcfs_pkg::IDX_W'(LastIdx));
  assign frame_ok  = (sum_next == win_q[rcfs_pkg::FRAME_BYTES-1]);

  // shared scaler sees steering first, then throttle
  always_comb begin
    if (state_q == rcfs_pkg::ST_THR) begin
      raw              = words_q[1];
      cutoff           = rcfs_pkg::THROTTLE_CUTOFF;
      chan_cfg.neutral = cfg_q[rcfs_pkg::REG_THROTTLE_NEUTRAL];
      chan_cfg.radius  = cfg_q[rcfs_pkg::REG_THROTTLE_RADIUS];
      chan_cfg.top     = cfg_q[rcfs_pkg::REG_THROTTLE_TOP];
      chan_cfg.bottom  = cfg_q[rcfs_pkg::REG_THROTTLE_BOTTOM];
    end else begin
      raw              = words_q[0];
      cutoff           = rcfs_pkg::STEER_CUTOFF;
      chan_cfg.neutral = cfg_q[rcfs_pkg::REG_STEER_NEUTRAL];
      chan_cfg.radius  = cfg_q[rcfs_pkg::REG_STEER_RADIUS];
      chan_cfg.top     = cfg_q[rcfs_pkg::REG_STEER_TOP];
      chan_cfg.bottom  = cfg_q[rcfs_pkg::REG_STEER_BOTTOM];
    end
  end

  rcfs_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .raw_i    (raw),
    .cutoff_i (cutoff),
    .cfg_i    (chan_cfg),
    .done_o   (scale_done),
    .level_o  (level)
  );

  always_comb begin
    if (!found_q) begin
      status = rcfs_pkg::LS_NO_FRAME;
    end else if (words_q[0] > rcfs_pkg::STEER_CUTOFF ||
                 words_q[1] > rcfs_pkg::THROTTLE_CUTOFF) begin
      status = rcfs_pkg::LS_RANGE;
    end else begin
      status = rcfs_pkg::LS_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcfs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (fill_next >= rcfs_pkg::FILL_W'(rcfs_pkg::FRAME_BYTES) && !found_q) begin
            state_d = rcfs_pkg::ST_SUM;
          end else if (in_data_i.buffer_end) begin
            state_d = rcfs_pkg::ST_STEER;
          end
        end
      end
      rcfs_pkg::ST_SUM: begin
        if (sum_done) state_d = last_q ? rcfs_pkg::ST_STEER : rcfs_pkg::ST_IDLE;
      end
      rcfs_pkg::ST_STEER: if (scale_done) state_d = rcfs_pkg::ST_THR;
      rcfs_pkg::ST_THR:   if (scale_done) state_d = rcfs_pkg::ST_OUT;
      rcfs_pkg::ST_OUT:   if (!out_valid_o || !out_stall_i) state_d = rcfs_pkg::ST_IDLE;
      default: state_d = rcfs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = (state_q != rcfs_pkg::ST_IDLE);
    out_load   = (state_q == rcfs_pkg::ST_OUT) && (!out_valid_o || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcfs_pkg::ST_IDLE;
      start_q     <= 1'b0;
      fill_q      <= '0;
      found_q     <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < rcfs_pkg::CFG_REGS; i++) cfg_q[i] <= rcfs_pkg::CFG_RESET[i];
      for (int i = 0; i < rcfs_pkg::FRAME_BYTES; i++) win_q[i] <= '0;
      for (int i = 0; i < rcfs_pkg::CHANNELS; i++) words_q[i] <= '0;
    end else begin
      state_q <= state_d;
      start_q <= (state_d != state_q) &&
                 (state_d == rcfs_pkg::ST_STEER || state_d == rcfs_pkg::ST_THR);
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_wdata_i;
      if (in_acc) begin
        for (int i = 0; i < rcfs_pkg::FRAME_BYTES - 1; i++) win_q[i] <= win_q[i+1];
        win_q[rcfs_pkg::FRAME_BYTES-1] <= in_data_i.rx_byte;
        fill_q <= fill_next;
      end
      if (state_q == rcfs_pkg::ST_SUM && sum_done && frame_ok) begin
        found_q <= 1'b1;
        for (int i = 0; i < rcfs_pkg::CHANNELS; i++) begin
          words_q[i] <= {win_q[1 + 2*i], win_q[2 + 2*i]};
        end
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
        fill_q      <= '0;
        found_q     <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_data_i.buffer_end;
      idx_q  <= '0;
      sum_q  <= '0;
    end else if (state_q == rcfs_pkg::ST_SUM) begin
      idx_q <= idx_q + 1'b1;
      sum_q <= sum_next;
    end
    if (state_q == rcfs_pkg::ST_STEER && scale_done) steer_q <= level;
    if (out_load) begin
      out_data_o.link_status    <= status;
      out_data_o.steer_level    <= steer_q;
      out_data_o.throttle_level <= level;
      out_data_o.aux_one_word   <= words_q[2];
      out_data_o.aux_two_word   <= words_q[3];
    end
  end

endmodule

`default_nettype wire

### src/rcfs_scale.sv
// ----------------------------------------------------------------------------
// rcfs_scale
// Dead zone scaling of one raw stick word to signed Q1.14 with a bit-serial
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfs_scale (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire  [15:0]             raw_i,
  input  wire  [15:0]             cutoff_i,
  input  rcfs_pkg::rcfs_chan_cfg_t cfg_i,
  output logic                    done_o,
  output logic signed [15:0]      level_o
);

  rcfs_pkg::rcfs_scale_state_e state_q, state_d;

  logic signed [17:0] d_q;
  logic               kill_q;
  logic [15:0]        num_q;
  logic signed [18:0] den_q;
  logic               neg_q;
  logic [17:0]        rem_q;
  logic [17:0]        dv_q;
  logic [14:0]        lo_q;
  logic [14:0]        q_q;
  logic [rcfs_pkg::CNT_W-1:0] cnt_q;

  logic signed [17:0] rad;
  logic               pos_side;
  logic               neg_side;
  logic signed [17:0] num_pos;
  logic signed [17:0] num_neg;
  logic signed [18:0] den_top;
  logic signed [18:0] den_bot;
  logic signed [18:0] den_abs;
  logic [16:0]        b;
  logic [31:0]        n_full;
  logic [17:0]        dv;
  logic               sat;
  logic [18:0]        rem_sh;
  logic               ge;
  logic [14:0]        mag;

  always_comb begin
    rad      = $signed({2'b00, cfg_i.radius});
    pos_side = d_q > rad;
    neg_side = d_q < -rad;
    num_pos  = d_q - rad;
    num_neg  = -(d_q + rad);
    den_top  = $signed({3'b000, cfg_i.top}) - $signed({3'b000, cfg_i.neutral})
               - $signed({3'b000, cfg_i.radius});
    den_bot  = $signed({3'b000, cfg_i.bottom}) - $signed({3'b000, cfg_i.neutral})
               + $signed({3'b000, cfg_i.radius});
    den_abs  = den_q[18] ? -den_q : den_q;
    b        = den_abs[16:0];
    // rounding: (2*num*16384 + b) / (2*b)
    n_full   = {1'b0, num_q, 15'b0} + {15'b0, b};
    dv       = {b, 1'b0};
    sat      = {1'b0, n_full[31:15]} >= dv;
    rem_sh   = {rem_q, lo_q[14]};
    ge       = rem_sh >= {1'b0, dv_q};
    mag      = (q_q > rcfs_pkg::Q_ONE) ? rcfs_pkg::Q_ONE : q_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcfs_pkg::SC_IDLE: if (start_i) state_d = rcfs_pkg::SC_DIFF;
      rcfs_pkg::SC_DIFF: state_d = rcfs_pkg::SC_SEL;
      rcfs_pkg::SC_SEL: begin
        if (kill_q || !(pos_side || neg_side)) state_d = rcfs_pkg::SC_FIN;
        else state_d = rcfs_pkg::SC_LOAD;
      end
      rcfs_pkg::SC_LOAD: begin
        if (den_q == '0 || sat) state_d = rcfs_pkg::SC_FIN;
        else state_d = rcfs_pkg::SC_DIV;
      end
      rcfs_pkg::SC_DIV: begin
        if (cnt_q == rcfs_pkg::CNT_W'(rcfs_pkg::DIV_STEPS - 1)) state_d = rcfs_pkg::SC_FIN;
      end
      rcfs_pkg::SC_FIN: state_d = rcfs_pkg::SC_IDLE;
      default: state_d = rcfs_pkg::SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o  = (state_q == rcfs_pkg::SC_FIN);
    level_o = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcfs_pkg::SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rcfs_pkg::SC_DIFF: begin
        d_q    <= $signed({2'b00, raw_i}) - $signed({2'b00, cfg_i.neutral});
        kill_q <= (raw_i == '0) || (raw_i > cutoff_i);
      end
      rcfs_pkg::SC_SEL: begin
        num_q  <= pos_side ? num_pos[15:0] : num_neg[15:0];
        den_q  <= pos_side ? den_top : den_bot;
        q_q    <= '0;
        neg_q  <= 1'b0;
      end
      rcfs_pkg::SC_LOAD: begin
        if (den_q == '0) begin
          q_q   <= rcfs_pkg::Q_ONE;
          neg_q <= 1'b0;
        end else begin
          neg_q <= den_q[18];
          q_q   <= sat ? rcfs_pkg::Q_ONE : '0;
        end
        rem_q <= {1'b0, n_full[31:15]};
        lo_q  <= n_full[14:0];
        dv_q  <= dv;
        cnt_q <= '0;
      end
      rcfs_pkg::SC_DIV: begin
        rem_q <= ge ? 18'(rem_sh - {1'b0, dv_q}) : rem_sh[17:0];
        lo_q  <= {lo_q[13:0], 1'b0};
        q_q   <= {q_q[13:0], ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/rcfs_checker.sv
// ----------------------------------------------------------------------------
// rcfs_checker
// Port level checks of the rc frame search and stick scaler.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_frame_search_and_stick_scaler_top_assert.svh"

module rcfs_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_i,
  input rcfs_pkg::rcfs_in_t  in_data_i,
  input wire                 out_valid_i,
  input wire                 out_stall_i,
  input rcfs_pkg::rcfs_out_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_i;

  // a stalled result keeps its value
  `RCFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "result changed under stall")

  // a byte that does not end the buffer never makes a result
  `RCFS_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, in_acc && !in_data_i.buffer_end && !out_valid_i, !out_valid_i, "result without buffer end")

  // buffer end always stalls the input, for the checksum pass or the scaling work
  `RCFS_ASSERT_NEXT(a_busy_after_end, clk_i, rst_ni, in_acc && in_data_i.buffer_end, in_stall_i, "request taken during scaling")

  // levels stay within plus or minus one
  `RCFS_ASSERT(a_level_range, clk_i, rst_ni, !out_valid_i || ((out_data_i.steer_level <= 16'sd16384) && (out_data_i.steer_level >= -16'sd16384) && (out_data_i.throttle_level <= 16'sd16384) && (out_data_i.throttle_level >= -16'sd16384)), "level out of range")

endmodule

bind rc_frame_search_and_stick_scaler_top rcfs_checker u_rcfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

### sim/tb_rc_frame_search_and_stick_scaler_top.sv
// ----------------------------------------------------------------------------
// tb_rc_frame_search_and_stick_scaler_top
// Self-checking bench for the rc frame search and stick scaler. Byte requests
// are built into receive buffers (clean frames, double frames, broken frames,
// short buffers, noise); a bench-side copy of the frame search and scaling
// predicts each buffer result, and every result taken from the block is
// compared field by field. Register settings change between phases while the
// block is quiet; idle patterns change between phases as well.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc_frame_search_and_stick_scaler_top;
  import rcfs_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  rcfs_in_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [15:0]          cfg_wdata = '0;
  wire                  in_stall;
  wire                  out_valid;
  rcfs_out_t            out_data;

  rc_frame_search_and_stick_scaler_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the block state
  rcfs_chan_cfg_t steer_cfg;
  rcfs_chan_cfg_t thr_cfg;
  logic [7:0]     win_bytes [FRAME_BYTES];
  int             win_fill;
  bit             frame_seen;
  logic [15:0]    chan_word [CHANNELS];

  rcfs_out_t      frame_result_q [$];
  rcfs_out_t      exp_r;
  logic [7:0]     buf_q [$];
  int             idle_pct  = 0;
  int             stall_pct = 0;
  int             fails     = 0;
  int             quiet_cnt = 0;

  function automatic rcfs_chan_cfg_t mk_chan(input logic [15:0] n, input logic [15:0] r,
                                             input logic [15:0] t, input logic [15:0] b);
    rcfs_chan_cfg_t c;
    c.neutral = n;
    c.radius  = r;
    c.top     = t;
    c.bottom  = b;
    return c;
  endfunction

  function automatic logic [15:0] scale_stick(input logic [15:0] raw,
                                              input logic [15:0] cutoff,
                                              input rcfs_chan_cfg_t c);
    longint d, rad, num, den, a, b, q;
    if (raw == 16'd0 || raw > cutoff) return 16'd0;
    d   = longint'(raw) - longint'(c.neutral);
    rad = longint'(c.radius);
    if (d > rad) begin
      num = d - rad;
      den = longint'(c.top) - longint'(c.neutral) - rad;
    end else if (d < -rad) begin
      num = -(d + rad);
      den = longint'(c.bottom) - longint'(c.neutral) + rad;
    end else begin
      return 16'd0;
    end
    if (den == 0) return 16'd16384;
    a = num * 16384;
    b = (den < 0) ? -den : den;
    // round half away from zero on the magnitude
    q = (2 * a + b) / (2 * b);
    if (q > 16384) q = 16384;
    return 16'((den < 0) ? -q : q);
  endfunction

  task automatic predict_byte(input rcfs_in_t req);
    logic [7:0] sum;
    rcfs_out_t  r;
    for (int i = 0; i < FRAME_BYTES - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[FRAME_BYTES - 1] = req.rx_byte;
    if (win_fill < FRAME_BYTES) win_fill++;
    sum = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + win_bytes[i];
    if (win_fill >= FRAME_BYTES && !frame_seen && sum == win_bytes[FRAME_BYTES - 1]) begin
      frame_seen = 1'b1;
      for (int i = 0; i < CHANNELS; i++) chan_word[i] = {win_bytes[1 + 2 * i], win_bytes[2 + 2 * i]};
    end
    if (req.buffer_end) begin
      if (!frame_seen) r.link_status = LS_NO_FRAME;
      else if (chan_word[0] > STEER_CUTOFF || chan_word[1] > THROTTLE_CUTOFF)
        r.link_status = LS_RANGE;
      else r.link_status = LS_OK;
      r.steer_level    = scale_stick(chan_word[0], STEER_CUTOFF, steer_cfg);
      r.throttle_level = scale_stick(chan_word[1], THROTTLE_CUTOFF, thr_cfg);
      r.aux_one_word   = chan_word[2];
      r.aux_two_word   = chan_word[3];
      frame_result_q.push_back(r);
      win_fill   = 0;
      frame_seen = 1'b0;
    end
  endtask

  // one byte request, with a random idle gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.rx_byte    <= b;
    in_data.buffer_end <= last;
    do @(posedge clk); while (in_stall);
    predict_byte('{rx_byte: b, buffer_end: last});
  endtask

  task automatic send_buffer(inout int sent);
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
    sent += buf_q.size();
    buf_q.delete();
  endtask

  task automatic add_noise(input int n);
    repeat (n) buf_q.push_back(8'($urandom));
  endtask

  task automatic add_frame(input logic [15:0] w0, input logic [15:0] w1,
                           input logic [15:0] w2, input logic [15:0] w3);
    logic [7:0] f [FRAME_BYTES];
    logic [7:0] sum;
    f[0] = 8'($urandom);
    {f[1], f[2]} = w0;
    {f[3], f[4]} = w1;
    {f[5], f[6]} = w2;
    {f[7], f[8]} = w3;
    sum = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum = sum + f[i];
    f[9] = sum;
    for (int i = 0; i < FRAME_BYTES; i++) buf_q.push_back(f[i]);
  endtask

  // stick words clustered on the scaling corners of the current setting
  function automatic logic [15:0] pick_stick(input rcfs_chan_cfg_t c, input logic [15:0] cutoff);
    case ($urandom_range(0, 13))
      0:       return 16'd0;
      1:       return c.neutral;
      2:       return c.neutral + c.radius;
      3:       return c.neutral + c.radius + 16'd1;
      4:       return c.neutral - c.radius;
      5:       return c.neutral - c.radius - 16'd1;
      6:       return c.top;
      7:       return c.bottom;
      8:       return cutoff;
      9:       return cutoff + 16'd1;
      10:      return 16'hffff;
      11:      return 16'($urandom);
      default: return 16'($urandom_range(1, 2200));
    endcase
  endfunction

  function automatic rcfs_chan_cfg_t rand_chan();
    logic [15:0] n, r;
    n = 16'($urandom_range(1200, 1800));
    r = 16'($urandom_range(0, 60));
    case ($urandom_range(0, 3))
      0:       return mk_chan(n, r, 16'($urandom_range(1800, 2100)),
                              16'($urandom_range(900, 1100)));
      1:       return mk_chan(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      2:       return mk_chan(n, r, n + r, n - r);
      default: return mk_chan(n, r, 16'd1000, 16'd2000);
    endcase
  endfunction

  // lower valid, let every pending result come out, then give the block time
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input rcfs_reg_e idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_STEER_NEUTRAL:    steer_cfg.neutral = v;
      REG_STEER_RADIUS:     steer_cfg.radius  = v;
      REG_STEER_TOP:        steer_cfg.top     = v;
      REG_STEER_BOTTOM:     steer_cfg.bottom  = v;
      REG_THROTTLE_NEUTRAL: thr_cfg.neutral   = v;
      REG_THROTTLE_RADIUS:  thr_cfg.radius    = v;
      REG_THROTTLE_TOP:     thr_cfg.top       = v;
      REG_THROTTLE_BOTTOM:  thr_cfg.bottom    = v;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input rcfs_chan_cfg_t s, input rcfs_chan_cfg_t t);
    wait_drained();
    write_reg(REG_STEER_NEUTRAL, s.neutral);
    write_reg(REG_STEER_RADIUS, s.radius);
    write_reg(REG_STEER_TOP, s.top);
    write_reg(REG_STEER_BOTTOM, s.bottom);
    write_reg(REG_THROTTLE_NEUTRAL, t.neutral);
    write_reg(REG_THROTTLE_RADIUS, t.radius);
    write_reg(REG_THROTTLE_TOP, t.top);
    write_reg(REG_THROTTLE_BOTTOM, t.bottom);
    cfg_we <= 1'b0;
  endtask

  // random buffers, mostly carrying a clean frame
  task automatic run_buffers(input int n_items);
    int sent, kind;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        add_noise($urandom_range(0, 4));
        add_frame(pick_stick(steer_cfg, STEER_CUTOFF), pick_stick(thr_cfg, THROTTLE_CUTOFF),
                  16'($urandom), 16'($urandom));
        add_noise($urandom_range(0, 4));
      end else if (kind < 70) begin
        add_noise($urandom_range(0, 2));
        add_frame(pick_stick(steer_cfg, STEER_CUTOFF), pick_stick(thr_cfg, THROTTLE_CUTOFF),
                  16'($urandom), 16'($urandom));
        add_noise($urandom_range(0, 2));
        add_frame(pick_stick(steer_cfg, STEER_CUTOFF), pick_stick(thr_cfg, THROTTLE_CUTOFF),
                  16'($urandom), 16'($urandom));
      end else if (kind < 78) begin
        // nominal full-length buffer
        add_noise($urandom_range(0, 22));
        add_frame(pick_stick(steer_cfg, STEER_CUTOFF), pick_stick(thr_cfg, THROTTLE_CUTOFF),
                  16'($urandom), 16'($urandom));
      end else if (kind < 86) begin
        // broken checksum byte
        add_frame(pick_stick(steer_cfg, STEER_CUTOFF), pick_stick(thr_cfg, THROTTLE_CUTOFF),
                  16'($urandom), 16'($urandom));
        buf_q[buf_q.size() - 1] = buf_q[buf_q.size() - 1] ^ 8'($urandom_range(1, 255));
        add_noise($urandom_range(0, 3));
      end else if (kind < 93) begin
        add_noise($urandom_range(1, FRAME_BYTES - 1));
      end else begin
        add_noise($urandom_range(FRAME_BYTES, 30));
      end
      send_buffer(sent);
    end
  endtask

  task automatic test_directed();
    int         sent;
    logic [7:0] x;
    sent = 0;
    // short buffer right after reset: no frame, zero words
    add_noise(3);
    send_buffer(sent);
    // exact frame with both sticks at full travel
    add_frame(steer_cfg.top, thr_cfg.bottom, 16'hffff, 16'h0000);
    send_buffer(sent);
    // a second valid window right after the first, first one must win
    add_frame(STEER_CUTOFF + 16'd1, 16'd0, 16'h1234, 16'habcd);
    x = buf_q[0];
    for (int i = 1; i < FRAME_BYTES - 1; i++) x = x + 8'(2 * buf_q[i]);
    buf_q.push_back(x);
    send_buffer(sent);
  endtask

  task automatic test_cfg_extremes();
    apply_cfg(mk_chan(16'd0, 16'd0, 16'd0, 16'd0), mk_chan(16'd0, 16'd0, 16'd0, 16'd0));
    run_buffers(40);
    apply_cfg(mk_chan(16'hffff, 16'hffff, 16'hffff, 16'hffff),
              mk_chan(16'hffff, 16'hffff, 16'hffff, 16'hffff));
    run_buffers(40);
    // zero denominator on both sides
    apply_cfg(mk_chan(16'd1500, 16'd20, 16'd1520, 16'd1480),
              mk_chan(16'd1000, 16'd0, 16'd1000, 16'd1000));
    run_buffers(40);
    apply_cfg(mk_chan(16'd0, 16'hffff, 16'd2000, 16'd1000),
              mk_chan(16'hffff, 16'd0, 16'd0, 16'hffff));
    run_buffers(40);
    // swapped end points give negative levels above center
    apply_cfg(mk_chan(16'd1500, 16'd10, 16'd1000, 16'd2000),
              mk_chan(16'd1500, 16'd10, 16'd1000, 16'd2000));
    run_buffers(40);
    apply_cfg(mk_chan(CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3]),
              mk_chan(CFG_RESET[4], CFG_RESET[5], CFG_RESET[6], CFG_RESET[7]));
    run_buffers(40);
  endtask

  task automatic test_drain_pause();
    idle_pct  = 20;
    stall_pct = 20;
    repeat (4) begin
      run_buffers(15);
      wait_drained();
    end
  endtask

  task automatic test_idle_phase(input int send_idle, input int recv_stall);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (3) begin
      apply_cfg(rand_chan(), rand_chan());
      run_buffers(85);
    end
  endtask

  // result side: random stall and comparison against the oldest prediction
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (frame_result_q.size() == 0) begin
        $error("result with no request pending");
        fails++;
      end else begin
        exp_r = frame_result_q.pop_front();
        if (out_data.link_status !== exp_r.link_status) begin
          $error("link_status expected %0d actual %0d", exp_r.link_status, out_data.link_status);
          fails++;
        end
        if (out_data.steer_level !== exp_r.steer_level) begin
          $error("steer_level expected %0d actual %0d", $signed(exp_r.steer_level),
                 $signed(out_data.steer_level));
          fails++;
        end
        if (out_data.throttle_level !== exp_r.throttle_level) begin
          $error("throttle_level expected %0d actual %0d", $signed(exp_r.throttle_level),
                 $signed(out_data.throttle_level));
          fails++;
        end
        if (out_data.aux_one_word !== exp_r.aux_one_word) begin
          $error("aux_one_word expected %0d actual %0d", exp_r.aux_one_word,
                 out_data.aux_one_word);
          fails++;
        end
        if (out_data.aux_two_word !== exp_r.aux_two_word) begin
          $error("aux_two_word expected %0d actual %0d", exp_r.aux_two_word,
                 out_data.aux_two_word);
          fails++;
        end
      end
    end
  end

  // cycles with no request, result or register write taken
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cnt <= 0;
      else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("[rc_frame_search_and_stick_scaler_top] ERROR");
        $finish;
      end else quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    steer_cfg  = mk_chan(CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3]);
    thr_cfg    = mk_chan(CFG_RESET[4], CFG_RESET[5], CFG_RESET[6], CFG_RESET[7]);
    win_fill   = 0;
    frame_seen = 1'b0;
    for (int i = 0; i < FRAME_BYTES; i++) win_bytes[i] = 8'd0;
    for (int i = 0; i < CHANNELS; i++) chan_word[i] = 16'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_cfg_extremes();
    test_drain_pause();
    test_idle_phase(0, 0);
    test_idle_phase(52, 0);
    test_idle_phase(0, 52);
    test_idle_phase(37, 37);

    wait_drained();
    if (fails == 0) begin
      $display("[rc_frame_search_and_stick_scaler_top] OK");
    end else begin
      $display("[rc_frame_search_and_stick_scaler_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
